### rtl/plc_pkg.sv
// types, register codes and per-byte judging functions for the printable length counter
// used by plc_flush and printable_length_counter; no dependencies
package plc_pkg;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  localparam logic [7:0] EscStartReset  = 8'd27;
  localparam logic [7:0] EscEndReset    = 8'd109;
  localparam logic [7:0] MkFirstReset   = 8'd37;
  localparam logic [7:0] MkSecondReset  = 8'd94;

  typedef enum logic [7:0] {
    RegEscStart = 8'd0,
    RegEscEnd   = 8'd1,
    RegMkFirst  = 8'd2,
    RegMkSecond = 8'd3
  } plc_reg_e;

  typedef struct packed {
    logic [7:0] esc_start;
    logic [7:0] esc_end;
    logic [7:0] mk_first;
    logic [7:0] mk_second;
  } plc_cfg_t;

  typedef struct packed {
    logic [7:0]        prev;
    logic              in_esc;
    logic              in_mk;
    logic              skip;
    logic [CountW-1:0] seq;
    logic [CountW-1:0] run;
  } plc_state_t;

  // string state handed over on the last byte, with the bytes still unjudged
  typedef struct packed {
    plc_state_t st;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two_held;
  } plc_flush_t;

  function automatic logic [CountW-1:0] plc_sat_add(logic [CountW-1:0] x, logic [1:0] k);
    logic [CountW:0] s;
    s = {1'b0, x} + {{(CountW-1){1'b0}}, k};
    return s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

  function automatic logic [CountW-1:0] plc_sat_sum(logic [CountW-1:0] a, logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

  // judge byte c given the next two bytes n1, n2 and whether they exist
  function automatic plc_state_t plc_judge(plc_state_t s, plc_cfg_t cfg, logic [7:0] c,
                                           logic v1, logic [7:0] n1,
                                           logic v2, logic [7:0] n2);
    plc_state_t r;
    logic       delim;
    r     = s;
    delim = (c == cfg.mk_first) && v1 && (n1 == cfg.mk_second);
    if (s.skip) begin
      r.skip = 1'b0;
    end else if (s.in_esc) begin
      if (c == cfg.esc_end) begin
        r.in_esc = 1'b0;
        r.seq    = '0;
      end else begin
        r.seq = plc_sat_add(s.seq, 2'd1);
      end
    end else if (s.in_mk) begin
      if (delim) begin
        r.in_mk = 1'b0;
        r.seq   = '0;
        r.skip  = 1'b1;
      end else begin
        r.seq = plc_sat_add(s.seq, 2'd1);
      end
    end else if (c == cfg.esc_start) begin
      r.in_esc = 1'b1;
      r.seq    = plc_sat_add(s.seq, 2'd1);
    end else if (delim && (s.run == '0 || s.prev != cfg.mk_first ||
                           !(v2 && n2 == cfg.mk_second))) begin
      r.in_mk = 1'b1;
      r.seq   = plc_sat_add(s.seq, 2'd2);
      r.skip  = 1'b1;
    end else begin
      r.run = plc_sat_add(s.run, 2'd1);
    end
    r.prev = c;
    return r;
  endfunction

endpackage

### rtl/plc_flush.sv
// end-of-string stages: judges the up to two held bytes and registers the count
// depends on plc_pkg
module plc_flush (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plc_pkg::plc_cfg_t   cfg_i,
  input  logic                flush_valid_i,
  input  plc_pkg::plc_flush_t flush_i,
  output logic                flush_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         printable_count_o
);

  logic                s1_v_q;
  plc_pkg::plc_flush_t s1_q;
  logic                s2_v_q;
  plc_pkg::plc_state_t s2_st_q;
  logic [7:0]          s2_rem_q;
  logic                out_v_q;
  logic [15:0]         out_q;

  logic                out_free;
  logic                s2_free;
  logic                s1_free;
  plc_pkg::plc_state_t s1_st;
  logic [7:0]          s1_rem;
  plc_pkg::plc_state_t s2_st;

  assign out_free      = !out_v_q || out_ready_i;
  assign s2_free       = !s2_v_q || out_free;
  assign s1_free       = !s1_v_q || s2_free;
  assign flush_ready_o = s1_free;

  // second to last byte, its follower is the last byte
  always_comb begin
    if (s1_q.two_held) begin
      s1_st  = plc_pkg::plc_judge(s1_q.st, cfg_i, s1_q.byte0, 1'b1, s1_q.byte1, 1'b0, 8'd0);
      s1_rem = s1_q.byte1;
    end else begin
      s1_st  = s1_q.st;
      s1_rem = s1_q.byte0;
    end
  end

  // last byte has no followers
  assign s2_st = plc_pkg::plc_judge(s2_st_q, cfg_i, s2_rem_q, 1'b0, 8'd0, 1'b0, 8'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= flush_valid_i;
      if (s2_free) s2_v_q <= s1_v_q;
      if (out_free) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && flush_valid_i) s1_q <= flush_i;
    if (s2_free && s1_v_q) begin
      s2_st_q  <= s1_st;
      s2_rem_q <= s1_rem;
    end
    if (out_free && s2_v_q) out_q <= plc_pkg::plc_sat_sum(s2_st.run, s2_st.seq);
  end

  assign out_valid_o       = out_v_q;
  assign printable_count_o = out_q;

endmodule

### rtl/printable_length_counter.sv
// printable length counter: out_valid_o follows the accepted last byte through the flush
// stages; throughput is one byte per cycle, out_ready_i low backs up into in_ready_o
// each byte is judged once the two bytes after it are known, the bytes still held at the
// end go through two flush stages before the output register
// reset clears all string state and loads the register defaults (27, 109, 37, 94)
// depends on plc_pkg and plc_flush
module printable_length_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] printable_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  plc_pkg::plc_cfg_t   cfg_q;
  plc_pkg::plc_state_t st_q, st_d;
  logic [7:0]          w0_q, w0_d, w1_q, w1_d;
  logic [1:0]          held_q, held_d;

  logic                accept;
  logic                flush_ready;
  plc_pkg::plc_flush_t flush;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = flush_ready;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    st_d   = st_q;
    w0_d   = w0_q;
    w1_d   = w1_q;
    held_d = held_q;
    if (held_q == 2'd2) begin
      st_d   = plc_pkg::plc_judge(st_q, cfg_q, w0_q, 1'b1, w1_q, 1'b1, char_byte_i);
      w0_d   = w1_q;
      w1_d   = char_byte_i;
    end else if (held_q == 2'd1) begin
      w1_d   = char_byte_i;
      held_d = 2'd2;
    end else begin
      w0_d   = char_byte_i;
      held_d = 2'd1;
    end
    flush.st       = st_d;
    flush.byte0    = w0_d;
    flush.byte1    = w1_d;
    flush.two_held = (held_d == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      w0_q   <= '0;
      w1_q   <= '0;
      held_q <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        // string handed to the flush stages, start clean
        st_q   <= '0;
        w0_q   <= '0;
        w1_q   <= '0;
        held_q <= '0;
      end else begin
        st_q   <= st_d;
        w0_q   <= w0_d;
        w1_q   <= w1_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.esc_start <= plc_pkg::EscStartReset;
      cfg_q.esc_end   <= plc_pkg::EscEndReset;
      cfg_q.mk_first  <= plc_pkg::MkFirstReset;
      cfg_q.mk_second <= plc_pkg::MkSecondReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        plc_pkg::RegEscStart: cfg_q.esc_start <= cfg_data_i;
        plc_pkg::RegEscEnd:   cfg_q.esc_end   <= cfg_data_i;
        plc_pkg::RegMkFirst:  cfg_q.mk_first  <= cfg_data_i;
        plc_pkg::RegMkSecond: cfg_q.mk_second <= cfg_data_i;
        default: ;
      endcase
    end
  end

  plc_flush u_flush (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .flush_valid_i     (in_valid_i && last_byte_i),
    .flush_i           (flush),
    .flush_ready_o     (flush_ready),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .printable_count_o (printable_count_o)
  );

endmodule

### dv/printable_length_counter_tb.sv
// testbench for printable_length_counter: drives byte strings, predicts the printable count
// of each finished string and checks every count; depends on plc_pkg and the rtl top level
`timescale 1ns / 100ps

module printable_length_counter_tb;

  localparam int unsigned MaxCount = 65535;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] printable_count_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  printable_length_counter uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .char_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_ready_i,
    .printable_count_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // predictor copy of the registers and the string state
  plc_pkg::plc_cfg_t cur_cfg;
  logic [7:0]  pr_prev;
  logic [7:0]  pr_win [2];
  int unsigned pr_held;
  bit          pr_in_esc;
  bit          pr_in_mk;
  bit          pr_skip;
  int unsigned pr_seq;
  int unsigned pr_run;

  logic [15:0] expected_counts [$];
  logic [7:0]  str_buf [$];

  bit idle_on;
  int errors;
  int n_strings;
  int n_bytes;
  int n_checked;
  int n_settings;

  initial begin
    clk_i = 1'b0;
  end
  always #2 clk_i = ~clk_i;

  function automatic int unsigned sat_add(int unsigned x, int unsigned k);
    return (x + k > MaxCount) ? MaxCount : x + k;
  endfunction

  // decide one byte, given the two that follow it and whether they exist
  task automatic judge_char(input logic [7:0] c, input bit v1, input logic [7:0] n1,
                            input bit v2, input logic [7:0] n2);
    bit delim;
    delim = (c == cur_cfg.mk_first) && v1 && (n1 == cur_cfg.mk_second);
    if (pr_skip) begin
      pr_skip = 1'b0;
    end else if (pr_in_esc) begin
      if (c == cur_cfg.esc_end) begin
        pr_in_esc = 1'b0;
        pr_seq    = 0;
      end else begin
        pr_seq = sat_add(pr_seq, 1);
      end
    end else if (pr_in_mk) begin
      if (delim) begin
        pr_in_mk = 1'b0;
        pr_seq   = 0;
        pr_skip  = 1'b1;
      end else begin
        pr_seq = sat_add(pr_seq, 1);
      end
    end else if (c == cur_cfg.esc_start) begin
      pr_in_esc = 1'b1;
      pr_seq    = sat_add(pr_seq, 1);
    end else if (delim && (pr_run == 0 || pr_prev != cur_cfg.mk_first ||
                           !(v2 && n2 == cur_cfg.mk_second))) begin
      pr_in_mk = 1'b1;
      pr_seq   = sat_add(pr_seq, 2);
      pr_skip  = 1'b1;
    end else begin
      pr_run = sat_add(pr_run, 1);
    end
    pr_prev = c;
  endtask

  task automatic predict_count(input logic [7:0] b, input bit last);
    int unsigned total;
    if (pr_held >= 2) begin
      judge_char(pr_win[0], 1'b1, pr_win[1], 1'b1, b);
      pr_win[0] = pr_win[1];
      pr_win[1] = b;
    end else begin
      pr_win[pr_held] = b;
      pr_held++;
    end
    if (last) begin
      // positions past the end of the string match nothing
      if (pr_held >= 2) begin
        judge_char(pr_win[0], 1'b1, pr_win[1], 1'b0, 8'h00);
        pr_win[0] = pr_win[1];
        pr_held   = 1;
      end
      if (pr_held == 1) begin
        judge_char(pr_win[0], 1'b0, 8'h00, 1'b0, 8'h00);
      end
      total = sat_add(pr_run, pr_seq);
      expected_counts.push_back(total[15:0]);
      pr_prev   = 8'h00;
      pr_win[0] = 8'h00;
      pr_win[1] = 8'h00;
      pr_held   = 0;
      pr_in_esc = 1'b0;
      pr_in_mk  = 1'b0;
      pr_skip   = 1'b0;
      pr_seq    = 0;
      pr_run    = 0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    while (idle_on && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_count(b, last);
    n_bytes++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_buf.size(); i++) begin
      send_byte(str_buf[i], i == str_buf.size() - 1);
    end
    n_strings++;
  endtask

  // wait for every count to come out, then let the flush stages settle
  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0 && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_config(input plc_pkg::plc_cfg_t c);
    plc_pkg::plc_reg_e idx [4];
    logic [7:0]        val [4];
    idx = '{plc_pkg::RegEscStart, plc_pkg::RegEscEnd, plc_pkg::RegMkFirst,
            plc_pkg::RegMkSecond};
    val = '{c.esc_start, c.esc_end, c.mk_first, c.mk_second};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cur_cfg = c;
    n_settings++;
  endtask

  function automatic plc_pkg::plc_cfg_t random_config();
    plc_pkg::plc_cfg_t c;
    c.esc_start = 8'($urandom_range(255));
    c.esc_end   = ($urandom_range(3) == 0) ? c.esc_start : 8'($urandom_range(255));
    c.mk_first  = ($urandom_range(5) == 0) ? c.esc_end : 8'($urandom_range(255));
    c.mk_second = ($urandom_range(3) == 0) ? c.mk_first : 8'($urandom_range(255));
    return c;
  endfunction

  // well-formed escapes and markup codes, with plain and broken pieces mixed in
  task automatic append_token();
    logic [7:0] specials [4];
    specials = '{cur_cfg.esc_start, cur_cfg.esc_end, cur_cfg.mk_first, cur_cfg.mk_second};
    case ($urandom_range(9))
      0, 1, 2: begin
        str_buf.push_back(8'($urandom_range(1, 255)));
      end
      3: begin
        str_buf.push_back(specials[$urandom_range(3)]);
      end
      4, 5: begin
        str_buf.push_back(cur_cfg.esc_start);
        repeat ($urandom_range(3)) str_buf.push_back(8'($urandom_range(1, 255)));
        str_buf.push_back(cur_cfg.esc_end);
      end
      6, 7: begin
        str_buf.push_back(cur_cfg.mk_first);
        str_buf.push_back(cur_cfg.mk_second);
        repeat ($urandom_range(3)) str_buf.push_back(8'($urandom_range(1, 255)));
        str_buf.push_back(cur_cfg.mk_first);
        str_buf.push_back(cur_cfg.mk_second);
      end
      8: begin
        str_buf.push_back(($urandom_range(1) != 0) ? cur_cfg.esc_start : cur_cfg.mk_first);
        if ($urandom_range(1) != 0) str_buf.push_back(cur_cfg.mk_second);
      end
      default: begin
        // doubled delimiter around a possible opening
        str_buf.push_back(cur_cfg.mk_first);
        str_buf.push_back(cur_cfg.mk_first);
        str_buf.push_back(cur_cfg.mk_second);
        str_buf.push_back(cur_cfg.mk_second);
      end
    endcase
  endtask

  task automatic make_string();
    int target;
    target = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
    str_buf.delete();
    while (str_buf.size() < target) append_token();
  endtask

  task automatic test_directed();
    str_buf = '{8'h61};
    send_string();
    str_buf = '{cur_cfg.esc_start, 8'h31, cur_cfg.esc_end, 8'h78};
    send_string();
    // escape left open at the end stays counted
    str_buf = '{cur_cfg.esc_start, 8'h61};
    send_string();
    str_buf = '{cur_cfg.mk_first, cur_cfg.mk_second, 8'h62,
                cur_cfg.mk_first, cur_cfg.mk_second, 8'h78};
    send_string();
    // opening blocked by the byte before and the byte two ahead
    str_buf = '{8'h61, cur_cfg.mk_first, cur_cfg.mk_first, cur_cfg.mk_second,
                cur_cfg.mk_second};
    send_string();
    str_buf = '{cur_cfg.mk_first, cur_cfg.mk_second, 8'h61};
    send_string();
    str_buf = '{8'h00, 8'h61, 8'hFF};
    send_string();
    // delimiter at the very end, lookahead past the end
    str_buf = '{8'h61, cur_cfg.mk_first, cur_cfg.mk_second};
    send_string();
    drain();
  endtask

  // strings with no idling on either side
  task automatic test_back_to_back();
    int start;
    idle_on = 1'b0;
    start   = n_bytes;
    while (n_bytes - start < 300) begin
      make_string();
      send_string();
    end
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_registers();
    plc_pkg::plc_cfg_t settings [3];
    settings = '{'{8'hFF, 8'h00, 8'h00, 8'hFF},
                 '{8'h00, 8'hFF, 8'hFF, 8'h00},
                 '{8'h61, 8'h61, 8'h61, 8'h61}};
    foreach (settings[s]) begin
      write_config(settings[s]);
      repeat (14) begin
        make_string();
        send_string();
      end
      drain();
    end
  endtask

  task automatic test_random();
    plc_pkg::plc_cfg_t c;
    int                start;
    for (int p = 0; p < 5; p++) begin
      c = (p == 0) ? plc_pkg::plc_cfg_t'({plc_pkg::EscStartReset, plc_pkg::EscEndReset,
                                          plc_pkg::MkFirstReset, plc_pkg::MkSecondReset})
                   : random_config();
      write_config(c);
      start = n_bytes;
      while (n_bytes - start < 230) begin
        make_string();
        send_string();
      end
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin : check_counts
    logic [15:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: count %0d with no string pending", $time, printable_count_o);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        n_checked++;
        if (printable_count_o !== want) begin
          $display("%0t: printable_count expected %0d, got %0d", $time, want,
                   printable_count_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("printable_length_counter_tb: errors");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_byte_i = 8'h00;
    last_byte_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 8'h00;
    cfg_data_i  = 8'h00;
    idle_on     = 1'b1;
    errors      = 0;
    n_strings   = 0;
    n_bytes     = 0;
    n_checked   = 0;
    n_settings  = 0;
    cur_cfg     = '{plc_pkg::EscStartReset, plc_pkg::EscEndReset, plc_pkg::MkFirstReset,
                    plc_pkg::MkSecondReset};
    pr_prev     = 8'h00;
    pr_win[0]   = 8'h00;
    pr_win[1]   = 8'h00;
    pr_held     = 0;
    pr_in_esc   = 1'b0;
    pr_in_mk    = 1'b0;
    pr_skip     = 1'b0;
    pr_seq      = 0;
    pr_run      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_back_to_back();
    test_registers();
    test_random();

    drain();
    if (expected_counts.size() != 0) begin
      $display("%0t: %0d counts never came out", $time, expected_counts.size());
      errors += expected_counts.size();
    end
    $display("covered %0d strings, %0d bytes, %0d counts checked over %0d register settings",
             n_strings, n_bytes, n_checked, n_settings);
    $display("a stretch with no idling and settings with shared special bytes were included");
    if (errors == 0) begin
      $display("printable_length_counter_tb: clean");
    end else begin
      $display("printable_length_counter_tb: errors");
    end
    $finish;
  end

endmodule
